// ===== design/lu_pkg.sv =====
// ----------------------------------------------------------------------------
// LU factorization package
// Widths, sizes and register codes shared by the LU factorization block.
// ----------------------------------------------------------------------------
package lu_pkg;

  // Largest matrix order held in the element store.
  localparam int MAX_ORDER = 8;
  // Fraction bits of the fixed-point element format.
  localparam int FRAC_BITS = 16;

  // Fixed widths of the port fields.
  localparam int ROW_W  = 3;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 4;

  // Derived widths for indexing, counting and arithmetic.
  localparam int IDX_W  = $clog2(MAX_ORDER);
  localparam int CNT_W  = $clog2(MAX_ORDER + 1);
  localparam int ADDR_W = $clog2(MAX_ORDER * MAX_ORDER);
  localparam int DIV_W  = VAL_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int PROD_W = 2 * VAL_W;
  localparam int SCL_W  = PROD_W - FRAC_BITS;
  localparam int DIFF_W = SCL_W + 1;

  // Register codes, selected by address bit 2.
  localparam logic REG_MATRIX_SIZE = 1'b0;

  // Store address of element (r, c) in row-major order.
  function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_ORDER + int'(c));
  endfunction

endpackage

// ===== design/lu_decomposition_in_place.sv =====
// ----------------------------------------------------------------------------
// LU decomposition in place
// Doolittle factorization without pivoting of a signed Q16.16 matrix, with
// one bit-serial divider and one multiplier shared under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one matrix element with its row and column and are
//   written to the element store, one per cycle while the block is idle.
//   The word with in_last set is stored and starts the factorization; in_ready
//   stays low until the last result word has been taken.
//   Each pivot is read and checked (PIV_RD, PIV_CHK). Each multiplier below a
//   pivot comes from the restoring divider that retires one quotient bit per
//   cycle over 48 bits. Each trailing update passes read, multiply, scale and
//   write back through the single multiplier and the store's write port.
//   The n*n result words then leave in row-major order, each read from the
//   store and loaded into the output register before the next is read; a low
//   out_ready holds the word in the output register and pauses the sequencer.
//   pivot_error and saturated hold for the whole run and clear at the next
//   start. Reset clears the sequencer, the flags and sets matrix_size to 8;
//   the store itself is not cleared.
// ----------------------------------------------------------------------------
module lu_decomposition_in_place (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lu_pkg::ROW_W-1:0]         in_row,
  input  logic [lu_pkg::ROW_W-1:0]         in_col,
  input  logic signed [lu_pkg::VAL_W-1:0]  in_value,
  input  logic                             in_last,
  // Output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lu_pkg::ROW_W-1:0]         out_row,
  output logic [lu_pkg::ROW_W-1:0]         out_col,
  output logic signed [lu_pkg::VAL_W-1:0]  out_value,
  output logic                             out_last,
  output logic                             pivot_error,
  output logic                             saturated
);

  typedef enum logic [3:0] {
    IDLE, PIV_RD, PIV_CHK, COL_RD, DIV_LD, DIV_RUN, DIV_WB,
    UPD_RD, UPD_MUL, UPD_SCL, UPD_WB, OUT_RD, OUT_LD, OUT_HOLD
  } state_t;

  state_t state;

  // Configuration and status registers
  logic [lu_pkg::SIZE_W-1:0] matrix_size;
  logic [lu_pkg::CNT_W-1:0]  n_use;
  logic [lu_pkg::CNT_W-1:0]  n_reg;
  logic                      pivot_flag;
  logic                      sat_flag;

  // Loop counters
  logic [lu_pkg::CNT_W-1:0] i_cnt, j_cnt, k_cnt, oi_cnt, oj_cnt;
  logic [lu_pkg::CNT_W-1:0] i_inc, j_inc, k_inc, oj_inc, n_dec;

  // Element store
  logic signed [lu_pkg::VAL_W-1:0] mem [lu_pkg::MAX_ORDER * lu_pkg::MAX_ORDER];
  logic [lu_pkg::ADDR_W-1:0]       ra, rb, waddr;
  logic signed [lu_pkg::VAL_W-1:0] rd_a, rd_b, wdata;
  logic                            we;

  // Divider
  logic                            piv_neg;
  logic [lu_pkg::VAL_W-1:0]        dvs;
  logic [lu_pkg::VAL_W-1:0]        rem;
  logic [lu_pkg::DIV_W-1:0]        dq;
  logic                            q_neg;
  logic [lu_pkg::DCNT_W-1:0]       div_cnt;
  logic [lu_pkg::VAL_W:0]          trial;
  logic                            trial_ge;
  logic [lu_pkg::VAL_W-1:0]        a_mag;
  logic                            q_ovf;
  logic signed [lu_pkg::VAL_W-1:0] m_val;

  // Multiply-subtract path
  logic signed [lu_pkg::VAL_W-1:0]  m_reg;
  logic signed [lu_pkg::VAL_W-1:0]  a_val;
  logic signed [lu_pkg::PROD_W-1:0] prod;
  logic signed [lu_pkg::PROD_W-1:0] prod_adj;
  logic signed [lu_pkg::SCL_W-1:0]  scaled;
  logic signed [lu_pkg::DIFF_W-1:0] diff;
  logic                             d_hi, d_lo;
  logic signed [lu_pkg::VAL_W-1:0]  d_val;

  logic in_fire, cfg_write, in_pos_ok;
  state_t after_i;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == lu_pkg::REG_MATRIX_SIZE) ? 32'(matrix_size) : '0;

  // Order in use, with zero read as one and large values clamped.
  always_comb begin
    if (matrix_size == '0) begin
      n_use = lu_pkg::CNT_W'(1);
    end else if (int'(matrix_size) > lu_pkg::MAX_ORDER) begin
      n_use = lu_pkg::CNT_W'(lu_pkg::MAX_ORDER);
    end else begin
      n_use = lu_pkg::CNT_W'(matrix_size);
    end
  end

  assign in_ready  = (state == IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_pos_ok = (int'(in_row) < lu_pkg::MAX_ORDER) &&
                     (int'(in_col) < lu_pkg::MAX_ORDER);

  assign i_inc  = i_cnt + lu_pkg::CNT_W'(1);
  assign j_inc  = j_cnt + lu_pkg::CNT_W'(1);
  assign k_inc  = k_cnt + lu_pkg::CNT_W'(1);
  assign oj_inc = oj_cnt + lu_pkg::CNT_W'(1);
  assign n_dec  = n_reg - lu_pkg::CNT_W'(1);
  assign after_i = (i_inc == n_reg) ? OUT_RD : PIV_RD;

  // One restoring step of the divider.
  assign trial    = {rem, dq[lu_pkg::DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs});
  assign a_mag    = rd_a[lu_pkg::VAL_W-1] ? lu_pkg::VAL_W'(-rd_a) : lu_pkg::VAL_W'(rd_a);

  // Signed, saturated quotient from the magnitude in dq.
  always_comb begin
    if (q_neg) begin
      q_ovf = (|dq[lu_pkg::DIV_W-1:lu_pkg::VAL_W]) ||
              (dq[lu_pkg::VAL_W-1] && (|dq[lu_pkg::VAL_W-2:0]));
      m_val = q_ovf ? {1'b1, {(lu_pkg::VAL_W-1){1'b0}}}
                    : -$signed(dq[lu_pkg::VAL_W-1:0]);
    end else begin
      q_ovf = |dq[lu_pkg::DIV_W-1:lu_pkg::VAL_W-1];
      m_val = q_ovf ? {1'b0, {(lu_pkg::VAL_W-1){1'b1}}}
                    : $signed(dq[lu_pkg::VAL_W-1:0]);
    end
  end

  // Product scaled by the fraction, truncated toward zero.
  assign prod_adj = prod + (prod[lu_pkg::PROD_W-1] ?
                    lu_pkg::PROD_W'((1 << lu_pkg::FRAC_BITS) - 1) : lu_pkg::PROD_W'(0));

  // Difference with saturation to the element range.
  assign diff  = lu_pkg::DIFF_W'(a_val) - lu_pkg::DIFF_W'(scaled);
  assign d_hi  = (diff > $signed(lu_pkg::DIFF_W'({1'b0, {(lu_pkg::VAL_W-1){1'b1}}})));
  assign d_lo  = (diff < -(lu_pkg::DIFF_W'(1) <<< (lu_pkg::VAL_W-1)));
  always_comb begin
    if (d_hi) begin
      d_val = {1'b0, {(lu_pkg::VAL_W-1){1'b1}}};
    end else if (d_lo) begin
      d_val = {1'b1, {(lu_pkg::VAL_W-1){1'b0}}};
    end else begin
      d_val = diff[lu_pkg::VAL_W-1:0];
    end
  end

  // Store addresses and write port, selected by the sequencer state.
  always_comb begin
    ra    = '0;
    rb    = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state)
      IDLE: begin
        we    = in_fire && in_pos_ok;
        waddr = lu_pkg::mat_addr(lu_pkg::IDX_W'(in_row), lu_pkg::IDX_W'(in_col));
        wdata = in_value;
      end
      PIV_RD: ra = lu_pkg::mat_addr(i_cnt[lu_pkg::IDX_W-1:0], i_cnt[lu_pkg::IDX_W-1:0]);
      COL_RD: ra = lu_pkg::mat_addr(j_cnt[lu_pkg::IDX_W-1:0], i_cnt[lu_pkg::IDX_W-1:0]);
      DIV_WB: begin
        we    = 1'b1;
        waddr = lu_pkg::mat_addr(j_cnt[lu_pkg::IDX_W-1:0], i_cnt[lu_pkg::IDX_W-1:0]);
        wdata = m_val;
      end
      UPD_RD: begin
        ra = lu_pkg::mat_addr(i_cnt[lu_pkg::IDX_W-1:0], k_cnt[lu_pkg::IDX_W-1:0]);
        rb = lu_pkg::mat_addr(j_cnt[lu_pkg::IDX_W-1:0], k_cnt[lu_pkg::IDX_W-1:0]);
      end
      UPD_WB: begin
        we    = 1'b1;
        waddr = lu_pkg::mat_addr(j_cnt[lu_pkg::IDX_W-1:0], k_cnt[lu_pkg::IDX_W-1:0]);
        wdata = d_val;
      end
      OUT_RD: ra = lu_pkg::mat_addr(oi_cnt[lu_pkg::IDX_W-1:0], oj_cnt[lu_pkg::IDX_W-1:0]);
      default: ;
    endcase
  end

  // Element store with one write and two registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= lu_pkg::SIZE_W'(8);
    end else if (cfg_write && paddr[2] == lu_pkg::REG_MATRIX_SIZE) begin
      matrix_size <= pwdata[lu_pkg::SIZE_W-1:0];
    end
  end

  // Sequencer, shared arithmetic registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      pivot_flag <= 1'b0;
      sat_flag   <= 1'b0;
      n_reg      <= '0;
      i_cnt      <= '0;
      j_cnt      <= '0;
      k_cnt      <= '0;
      oi_cnt     <= '0;
      oj_cnt     <= '0;
      div_cnt    <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_fire && in_last) begin
            pivot_flag <= 1'b0;
            sat_flag   <= 1'b0;
            n_reg      <= n_use;
            i_cnt      <= '0;
            state      <= PIV_RD;
          end
        end
        PIV_RD: state <= PIV_CHK;
        PIV_CHK: begin
          piv_neg <= rd_a[lu_pkg::VAL_W-1];
          dvs     <= rd_a[lu_pkg::VAL_W-1] ? lu_pkg::VAL_W'(-rd_a) : lu_pkg::VAL_W'(rd_a);
          if (rd_a == '0 || i_inc == n_reg) begin
            // Zero pivot skips the column; the final pivot has nothing below.
            if (rd_a == '0) begin
              pivot_flag <= 1'b1;
            end
            i_cnt  <= i_inc;
            oi_cnt <= '0;
            oj_cnt <= '0;
            state  <= after_i;
          end else begin
            j_cnt <= i_inc;
            state <= COL_RD;
          end
        end
        COL_RD: state <= DIV_LD;
        DIV_LD: begin
          rem     <= '0;
          dq      <= {a_mag, {lu_pkg::FRAC_BITS{1'b0}}};
          q_neg   <= rd_a[lu_pkg::VAL_W-1] ^ piv_neg;
          div_cnt <= '0;
          state   <= DIV_RUN;
        end
        DIV_RUN: begin
          rem     <= trial_ge ? lu_pkg::VAL_W'(trial - {1'b0, dvs})
                              : trial[lu_pkg::VAL_W-1:0];
          dq      <= {dq[lu_pkg::DIV_W-2:0], trial_ge};
          div_cnt <= div_cnt + lu_pkg::DCNT_W'(1);
          if (div_cnt == lu_pkg::DCNT_W'(lu_pkg::DIV_W - 1)) begin
            state <= DIV_WB;
          end
        end
        DIV_WB: begin
          m_reg <= m_val;
          if (q_ovf) begin
            sat_flag <= 1'b1;
          end
          k_cnt <= i_inc;
          state <= UPD_RD;
        end
        UPD_RD: state <= UPD_MUL;
        UPD_MUL: begin
          prod  <= m_reg * rd_a;
          a_val <= rd_b;
          state <= UPD_SCL;
        end
        UPD_SCL: begin
          scaled <= prod_adj[lu_pkg::PROD_W-1:lu_pkg::FRAC_BITS];
          state  <= UPD_WB;
        end
        UPD_WB: begin
          if (d_hi || d_lo) begin
            sat_flag <= 1'b1;
          end
          if (k_inc != n_reg) begin
            k_cnt <= k_inc;
            state <= UPD_RD;
          end else if (j_inc != n_reg) begin
            j_cnt <= j_inc;
            state <= COL_RD;
          end else begin
            i_cnt  <= i_inc;
            oi_cnt <= '0;
            oj_cnt <= '0;
            state  <= after_i;
          end
        end
        OUT_RD: state <= OUT_LD;
        OUT_LD: begin
          out_row   <= lu_pkg::ROW_W'(oi_cnt);
          out_col   <= lu_pkg::ROW_W'(oj_cnt);
          out_value <= rd_a;
          out_last  <= (oi_cnt == n_dec) && (oj_cnt == n_dec);
          out_valid <= 1'b1;
          state     <= OUT_HOLD;
        end
        OUT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= IDLE;
            end else begin
              if (oj_inc == n_reg) begin
                oj_cnt <= '0;
                oi_cnt <= oi_cnt + lu_pkg::CNT_W'(1);
              end else begin
                oj_cnt <= oj_inc;
              end
              state <= OUT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign pivot_error = pivot_flag;
  assign saturated   = sat_flag;

  // The block never takes input while a result word is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result word is pending");

  // A word marked last starts the pivot loop in the next cycle.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> (state == PIV_RD))
    else $error("factorization did not start after the last word");

  // Every update writes inside the trailing submatrix of the current pivot.
  a_upd_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == UPD_WB) |-> (j_cnt > i_cnt && k_cnt > i_cnt &&
                           j_cnt < n_reg && k_cnt < n_reg))
    else $error("update outside the trailing submatrix");

  // The end-of-run mark only appears on the bottom-right element.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (oi_cnt == n_dec && oj_cnt == n_dec))
    else $error("end-of-run mark on the wrong element");

endmodule

// ===== tb/tb_lu_decomposition_in_place.sv =====
// ----------------------------------------------------------------------------
// Testbench for the in-place LU decomposition block
// Loads matrices word by word and lets an internal Doolittle model predict
// every factor word, then checks the block's output words field by field
// under random input gaps, output stalls and a range of matrix orders.
// ----------------------------------------------------------------------------
module tb_lu_decomposition_in_place;

  localparam int Q_ONE = 1 << lu_pkg::FRAC_BITS;
  localparam int RANDOM_WORDS = 320;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 20000000;
  localparam logic [2:0] ADDR_MATRIX_SIZE = {lu_pkg::REG_MATRIX_SIZE, 2'b00};
  localparam logic [2:0] ADDR_SPARE = {~lu_pkg::REG_MATRIX_SIZE, 2'b00};
  localparam logic signed [lu_pkg::VAL_W-1:0] Q_MAX_WORD = 32'sh7FFFFFFF;
  localparam logic signed [lu_pkg::VAL_W-1:0] Q_MIN_WORD = 32'sh80000000;

  // One output word of the block.
  typedef struct packed {
    logic [lu_pkg::ROW_W-1:0]        row;
    logic [lu_pkg::ROW_W-1:0]        col;
    logic signed [lu_pkg::VAL_W-1:0] value;
    logic                            last;
    logic                            pivot_err;
    logic                            sat;
  } lu_word_t;

  // Kinds of matrix content sent in one load.
  typedef enum int {
    STYLE_DOMINANT,
    STYLE_SMALL,
    STYLE_WILD,
    STYLE_SINGULAR,
    STYLE_TINY
  } set_style_t;

  // The factorization model and the queue of factor words it predicts.
  class lu_factor_checker_t;
    logic signed [lu_pkg::VAL_W-1:0] elem [lu_pkg::MAX_ORDER*lu_pkg::MAX_ORDER];
    logic [lu_pkg::SIZE_W-1:0] size_reg = 4'd8;
    bit pivot_bad;
    bit clipped;
    lu_word_t factor_words [$];
    int errors;
    int at_row;
    int at_col;

    function void note_config(logic [2:0] addr, logic [31:0] data);
      if (addr[2] == lu_pkg::REG_MATRIX_SIZE) size_reg = data[lu_pkg::SIZE_W-1:0];
    endfunction

    // Saturate to the 32-bit word range and remember that it happened.
    function logic signed [lu_pkg::VAL_W-1:0] clamp_word(longint v);
      if (v > 64'sd2147483647) begin
        clipped = 1'b1;
        return Q_MAX_WORD;
      end
      if (v < -64'sd2147483648) begin
        clipped = 1'b1;
        return Q_MIN_WORD;
      end
      return v[lu_pkg::VAL_W-1:0];
    endfunction

    // Doolittle elimination without pivoting; a zero pivot skips its column.
    function void factor_in_place(int n);
      longint pivot;
      longint mult;
      longint upper;
      longint prod;
      for (int i = 0; i < n; i++) begin
        pivot = elem[i*lu_pkg::MAX_ORDER+i];
        if (pivot == 0) begin
          pivot_bad = 1'b1;
          continue;
        end
        for (int j = i + 1; j < n; j++) begin
          mult = clamp_word((longint'(elem[j*lu_pkg::MAX_ORDER+i]) * Q_ONE) / pivot);
          elem[j*lu_pkg::MAX_ORDER+i] = mult[lu_pkg::VAL_W-1:0];
          for (int k = i + 1; k < n; k++) begin
            upper = elem[i*lu_pkg::MAX_ORDER+k];
            prod = (mult * upper) / Q_ONE;
            elem[j*lu_pkg::MAX_ORDER+k] =
                clamp_word(longint'(elem[j*lu_pkg::MAX_ORDER+k]) - prod);
          end
        end
      end
    endfunction

    // Store an accepted word; the last word of a load produces the factors.
    function void note_word(logic [lu_pkg::ROW_W-1:0] r, logic [lu_pkg::ROW_W-1:0] c,
                            logic signed [lu_pkg::VAL_W-1:0] v, logic last);
      int n;
      lu_word_t w;
      elem[int'(r)*lu_pkg::MAX_ORDER + int'(c)] = v;
      if (!last) return;
      pivot_bad = 1'b0;
      clipped = 1'b0;
      n = (size_reg == 0) ? 1 :
          (size_reg > lu_pkg::MAX_ORDER) ? lu_pkg::MAX_ORDER : int'(size_reg);
      factor_in_place(n);
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          w.row = lu_pkg::ROW_W'(i);
          w.col = lu_pkg::ROW_W'(j);
          w.value = elem[i*lu_pkg::MAX_ORDER+j];
          w.last = (i == n - 1) && (j == n - 1);
          w.pivot_err = pivot_bad;
          w.sat = clipped;
          factor_words.push_back(w);
        end
      end
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch at (%0d,%0d): expected %0d, got %0d",
                 $time, name, at_row, at_col, want, got);
        errors++;
      end
    endfunction

    function void check_word(lu_word_t got);
      lu_word_t want;
      if (factor_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got (%0d,%0d) value %0d",
                 $time, got.row, got.col, got.value);
        errors++;
        return;
      end
      want = factor_words.pop_front();
      at_row = want.row;
      at_col = want.col;
      compare_field("out_row", want.row, got.row);
      compare_field("out_col", want.col, got.col);
      compare_field("out_value", want.value, got.value);
      compare_field("out_last", want.last, got.last);
      compare_field("pivot_error", want.pivot_err, got.pivot_err);
      compare_field("saturated", want.sat, got.sat);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [lu_pkg::ROW_W-1:0] in_row;
  logic [lu_pkg::ROW_W-1:0] in_col;
  logic signed [lu_pkg::VAL_W-1:0] in_value;
  logic in_last;
  logic out_valid;
  logic out_ready;
  logic [lu_pkg::ROW_W-1:0] out_row;
  logic [lu_pkg::ROW_W-1:0] out_col;
  logic signed [lu_pkg::VAL_W-1:0] out_value;
  logic out_last;
  logic pivot_error;
  logic saturated;

  lu_factor_checker_t sb;
  lu_word_t seen;
  bit loaded [lu_pkg::MAX_ORDER*lu_pkg::MAX_ORDER];
  bit hold_off_req;
  int words_sent;
  int cycle_count;

  lu_decomposition_in_place dut (.*);

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output monitor: every accepted word goes to the checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.row = out_row;
      seen.col = out_col;
      seen.value = out_value;
      seen.last = out_last;
      seen.pivot_err = pivot_error;
      seen.sat = saturated;
      sb.check_word(seen);
    end
  end

  function automatic bit region_loaded(int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!loaded[r*lu_pkg::MAX_ORDER+c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Element value for position (r, c) of a load of the given kind.
  function automatic logic signed [lu_pkg::VAL_W-1:0] pick_value(set_style_t style,
                                                                 int r, int c,
                                                                 int n, int zero_row);
    int mag;
    logic signed [lu_pkg::VAL_W-1:0] v;
    case (style)
      STYLE_SMALL: v = lu_pkg::VAL_W'(int'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE);
      STYLE_WILD: begin
        case ($urandom_range(0, 9))
          0: v = Q_MAX_WORD;
          1: v = Q_MIN_WORD;
          2: v = '0;
          default: v = $urandom();
        endcase
      end
      STYLE_TINY: begin
        v = (r == c) ? lu_pkg::VAL_W'(int'($urandom_range(0, 32)) - 16) : $urandom();
      end
      default: begin
        // A heavy diagonal keeps the multipliers small.
        if (r == c) begin
          mag = (n + 1) * Q_ONE + int'($urandom_range(0, 3 * Q_ONE));
          v = $urandom_range(0, 1) ? lu_pkg::VAL_W'(mag) : lu_pkg::VAL_W'(-mag);
        end else begin
          v = lu_pkg::VAL_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
        end
        // A zero row leaves a zero pivot however the rows above eliminate.
        if (style == STYLE_SINGULAR && r == zero_row) v = '0;
      end
    endcase
    return v;
  endfunction

  // Configuration access: setup cycle, then access cycle.
  task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (wr) begin
      sb.note_config(addr, data);
    end else if (prdata[lu_pkg::SIZE_W-1:0] !== sb.size_reg) begin
      $display("%0t: matrix_size read back: expected %0d, got %0d",
               $time, sb.size_reg, prdata[lu_pkg::SIZE_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one element word after an optional gap and wait for acceptance.
  task automatic send_word(input int r, input int c,
                           input logic signed [lu_pkg::VAL_W-1:0] v,
                           input bit last, input bit quiet);
    int gap;
    gap = pick_gap(quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_row <= lu_pkg::ROW_W'(r);
    in_col <= lu_pkg::ROW_W'(c);
    in_value <= v;
    in_last <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(lu_pkg::ROW_W'(r), lu_pkg::ROW_W'(c), v, last);
    loaded[r*lu_pkg::MAX_ORDER+c] = 1'b1;
    words_sent++;
  endtask

  // One load of the active corner, ending with the word that starts the run.
  // A partial load rewrites only some entries and relies on the store.
  task automatic send_set(input int n, input set_style_t style, input bit partial,
                          input bit quiet);
    int spots [$];
    int zero_row;
    int tmp;
    int pick;
    int r;
    int c;
    zero_row = $urandom_range(0, n - 1);
    if (partial && region_loaded(n)) begin
      repeat ($urandom_range(1, n * n)) spots.push_back($urandom_range(0, n * n - 1));
    end else begin
      for (int x = 0; x < n * n; x++) spots.push_back(x);
      for (int x = n * n - 1; x > 0; x--) begin
        pick = $urandom_range(0, x);
        tmp = spots[x];
        spots[x] = spots[pick];
        spots[pick] = tmp;
      end
    end
    for (int x = 0; x < spots.size(); x++) begin
      // Now and then a stray word lands outside the active corner.
      if (n < lu_pkg::MAX_ORDER && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(n, lu_pkg::MAX_ORDER - 1);
          c = $urandom_range(0, lu_pkg::MAX_ORDER - 1);
        end else begin
          r = $urandom_range(0, lu_pkg::MAX_ORDER - 1);
          c = $urandom_range(n, lu_pkg::MAX_ORDER - 1);
        end
        send_word(r, c, $urandom(), 1'b0, quiet);
      end
      r = spots[x] / n;
      c = spots[x] % n;
      send_word(r, c, pick_value(style, r, c, n, zero_row), x == spots.size() - 1, quiet);
    end
  endtask

  // Stop offering words and wait until every predicted word has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.factor_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output side: random stalls, quiet stretches, and one long hold-off.
  initial begin : receiver
    int hold_left;
    int stall_left;
    int run_left;
    hold_left = 0;
    stall_left = 0;
    run_left = 0;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req && out_valid) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 16);
          case ($urandom_range(0, 19))
            0: stall_left = $urandom_range(20, 60);
            1, 2, 3, 4, 5, 6, 7: stall_left = $urandom_range(1, 4);
            default: stall_left = 0;
          endcase
        end
      end
    end
  end

  // Main sequence: reset, directed loads, then random phases.
  initial begin : stimulus
    int cfg;
    int n;
    int sets;
    int phase;
    int random_start;
    int roll;
    bit quiet;
    sb = new;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    in_last = 1'b0;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Order 1: zero pivot, both extremes, and a stray word before the last.
    reg_access(1'b0, ADDR_MATRIX_SIZE, '0);
    reg_access(1'b1, ADDR_MATRIX_SIZE, 32'd1);
    send_word(0, 0, '0, 1'b1, 1'b0);
    send_word(0, 0, Q_MAX_WORD, 1'b1, 1'b0);
    send_word(0, 0, Q_MIN_WORD, 1'b1, 1'b0);
    send_word(6, 5, $urandom(), 1'b0, 1'b0);
    send_word(0, 0, Q_ONE, 1'b1, 1'b0);
    settle();

    // A write past the register list changes nothing; order 0 acts as 1.
    reg_access(1'b1, ADDR_SPARE, 32'd2);
    reg_access(1'b1, ADDR_MATRIX_SIZE, 32'd0);
    reg_access(1'b0, ADDR_MATRIX_SIZE, '0);
    send_word(0, 0, -Q_ONE, 1'b1, 1'b0);
    settle();

    // Order 2: a zero leading pivot, then a tiny pivot that saturates.
    reg_access(1'b1, ADDR_MATRIX_SIZE, 32'hFFFF_FFF2);
    send_word(0, 0, '0, 1'b0, 1'b0);
    send_word(0, 1, Q_ONE, 1'b0, 1'b0);
    send_word(1, 0, 2 * Q_ONE, 1'b0, 1'b0);
    send_word(1, 1, 3 * Q_ONE, 1'b1, 1'b0);
    send_word(0, 0, 1, 1'b0, 1'b0);
    send_word(0, 1, Q_MAX_WORD, 1'b0, 1'b0);
    send_word(1, 1, Q_MIN_WORD, 1'b0, 1'b0);
    send_word(1, 0, Q_MAX_WORD, 1'b1, 1'b0);
    settle();

    // Order 3, all entries at the most negative value: the second pivot is zero.
    reg_access(1'b1, ADDR_MATRIX_SIZE, 32'd3);
    for (int x = 0; x < 9; x++) send_word(x / 3, x % 3, Q_MIN_WORD, x == 8, 1'b0);

    // Random phases. The first one fills the block behind a long output
    // hold-off; the second loads the full matrix through an oversized order.
    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      case (phase)
        0: cfg = 4;
        1: cfg = 15;
        default: begin
          roll = $urandom_range(0, 99);
          if (roll < 8) cfg = $urandom_range(8, 15);
          else if (roll < 12) cfg = 0;
          else if (roll < 40) cfg = $urandom_range(1, 2);
          else cfg = $urandom_range(3, 7);
        end
      endcase
      settle();
      reg_access(1'b1, ADDR_MATRIX_SIZE, ($urandom() & 32'hFFFF_FFF0) | 32'(cfg));
      if ($urandom_range(0, 3) == 0) begin
        reg_access(1'b1, ADDR_SPARE, $urandom());
        reg_access(1'b0, ADDR_MATRIX_SIZE, '0);
      end
      n = (cfg == 0) ? 1 : (cfg > lu_pkg::MAX_ORDER) ? lu_pkg::MAX_ORDER : cfg;
      quiet = (phase != 0) && ($urandom_range(0, 3) == 0);
      sets = (phase == 0) ? 3 : $urandom_range(1, 3);
      if (phase == 0) hold_off_req = 1'b1;
      repeat (sets) begin
        send_set(n, set_style_t'($urandom_range(0, 4)), $urandom_range(0, 2) == 0, quiet);
      end
      phase++;
    end

    settle();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
